/* hw/rtl/bmcs_pkg.sv */
// ----------------------------------------------------------------------------
// bmcs_pkg - shared types and constants of the bracket completion scorer
// Field widths, bracket character codes, kind decoders and sequencer states.
// ----------------------------------------------------------------------------
package bmcs_pkg;

  localparam int SYMBOL_W        = 8;
  localparam int SCORE_W         = 64;
  localparam int COUNT_W         = 7;
  localparam int KIND_W          = 2;
  localparam int DEF_STACK_DEPTH = 64;
  localparam int COUNT_MAX       = 127;

  // Bracket characters
  localparam logic [SYMBOL_W-1:0] CH_PAREN_OPEN  = 8'h28;  // (
  localparam logic [SYMBOL_W-1:0] CH_PAREN_CLOSE = 8'h29;  // )
  localparam logic [SYMBOL_W-1:0] CH_SQ_OPEN     = 8'h5B;  // [
  localparam logic [SYMBOL_W-1:0] CH_SQ_CLOSE    = 8'h5D;  // ]
  localparam logic [SYMBOL_W-1:0] CH_CURLY_OPEN  = 8'h7B;  // {
  localparam logic [SYMBOL_W-1:0] CH_CURLY_CLOSE = 8'h7D;  // }
  localparam logic [SYMBOL_W-1:0] CH_ANGLE_OPEN  = 8'h3C;  // <
  localparam logic [SYMBOL_W-1:0] CH_ANGLE_CLOSE = 8'h3E;  // >

  // Kind codes held on the stack
  localparam logic [KIND_W-1:0] KIND_PAREN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURLY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd3;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } kind_dec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_WALK,
    S_FIN
  } bmcs_state_t;

  // Decode an opening bracket
  function automatic kind_dec_t open_decode(input logic [SYMBOL_W-1:0] ch);
    kind_dec_t d;
    d.hit  = 1'b1;
    d.kind = KIND_PAREN;
    case (ch)
      CH_PAREN_OPEN: d.kind = KIND_PAREN;
      CH_SQ_OPEN:    d.kind = KIND_SQ;
      CH_CURLY_OPEN: d.kind = KIND_CURLY;
      CH_ANGLE_OPEN: d.kind = KIND_ANGLE;
      default:       d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  // Decode a closing bracket
  function automatic kind_dec_t close_decode(input logic [SYMBOL_W-1:0] ch);
    kind_dec_t d;
    d.hit  = 1'b1;
    d.kind = KIND_PAREN;
    case (ch)
      CH_PAREN_CLOSE: d.kind = KIND_PAREN;
      CH_SQ_CLOSE:    d.kind = KIND_SQ;
      CH_CURLY_CLOSE: d.kind = KIND_CURLY;
      CH_ANGLE_CLOSE: d.kind = KIND_ANGLE;
      default:        d.hit  = 1'b0;
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/bmcs_in_if.sv */
// ----------------------------------------------------------------------------
// bmcs_in_if - character input channel
// Valid/ready channel carrying one character and its line-end mark per item.
// ----------------------------------------------------------------------------
interface bmcs_in_if
  import bmcs_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                line_end;

  modport source (output valid, output symbol, output line_end, input ready);
  modport sink   (input valid, input symbol, input line_end, output ready);
endinterface

/* hw/rtl/bmcs_out_if.sv */
// ----------------------------------------------------------------------------
// bmcs_out_if - line result channel
// Valid/ready channel carrying one line result per item.
// ----------------------------------------------------------------------------
interface bmcs_out_if
  import bmcs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               corrupt;
  logic [SCORE_W-1:0] completion_score;
  logic [COUNT_W-1:0] open_count;
  logic               stack_overflow;
  logic               score_wrapped;

  modport source (output valid, output corrupt, output completion_score,
                  output open_count, output stack_overflow, output score_wrapped,
                  input ready);
  modport sink   (input valid, input corrupt, input completion_score,
                  input open_count, input stack_overflow, input score_wrapped,
                  output ready);
endinterface

/* hw/rtl/bmcs_ram.sv */
// ----------------------------------------------------------------------------
// bmcs_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bmcs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/bmcs_mac5.sv */
// ----------------------------------------------------------------------------
// bmcs_mac5 - shared score step unit
// Forms acc*5 + kind + 1 modulo 2^64 and flags a carry out of 64 bits.
// ----------------------------------------------------------------------------
module bmcs_mac5
  import bmcs_pkg::*;
(
  input  logic [SCORE_W-1:0] acc_i,
  input  logic [KIND_W-1:0]  kind_i,
  output logic [SCORE_W-1:0] acc_o,
  output logic               carry_o
);

  localparam int EXT_W = SCORE_W + 3;

  logic [EXT_W-1:0] acc_ext;
  logic [EXT_W-1:0] sum;

  // Times five as shift plus add, then add the digit
  assign acc_ext = EXT_W'(acc_i);
  assign sum     = (acc_ext << 2) + acc_ext + EXT_W'(kind_i) + EXT_W'(1);
  assign acc_o   = sum[SCORE_W-1:0];
  assign carry_o = |sum[EXT_W-1:SCORE_W];

endmodule

/* hw/rtl/bracket_match_completion_score.sv */
// ----------------------------------------------------------------------------
// bracket_match_completion_score - bracket checker with completion score
// Pushes opening brackets on a stack RAM, checks closing brackets against the
// top, and at line end walks the stack top first through a shared x5+digit
// unit to form the completion score.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+------------------------------------
//   in_ch    | in  | valid/ready       | symbol[7:0], line_end
//   out_ch   | out | valid/ready       | corrupt, completion_score[63:0],
//            |     |                   | open_count[6:0], stack_overflow,
//            |     |                   | score_wrapped
//
// An ordinary or opening character is taken in S_IDLE alone; a closing bracket
// with a bracket open on a sound line also passes S_CMP, as the top of stack
// comes back from the registered RAM read. A line end then walks the stack in
// S_WALK (skipped on a corrupt line) and loads the result in S_FIN.
// The result waits in an output register; only the next line end stalls on it.
// rst_n is synchronous; the stack RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module bracket_match_completion_score
  import bmcs_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  bmcs_in_if.sink           in_ch,
  bmcs_out_if.source        out_ch
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (DW > COUNT_W) ? DW : COUNT_W;

  bmcs_state_t state_r, state_nxt;

  logic [DW-1:0]      depth_r, depth_nxt;
  logic               corrupt_r, corrupt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic               line_end_r, line_end_nxt;
  logic [DW-1:0]      walk_idx_r, walk_idx_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic               wrap_r, wrap_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_corrupt_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_ovf_r;
  logic               out_wrap_r;

  logic               in_fire;
  kind_dec_t          od, cd;
  logic               close_read;
  logic               load;
  logic               walk_start;
  logic [DW-1:0]      depth_prev;
  logic [DW-1:0]      walk_prev;
  logic [CW-1:0]      depth_w;
  logic [COUNT_W-1:0] depth_sat;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [KIND_W-1:0]  mem_rdata;
  logic [SCORE_W-1:0] mac_acc;
  logic               mac_carry;

  // Stack storage
  bmcs_ram #(
    .WIDTH (KIND_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (od.kind),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Shared score step
  bmcs_mac5 u_mac5 (
    .acc_i   (score_r),
    .kind_i  (mem_rdata),
    .acc_o   (mac_acc),
    .carry_o (mac_carry)
  );

  // Decode the incoming character
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign od           = open_decode(in_ch.symbol);
  assign cd           = close_decode(in_ch.symbol);
  assign close_read   = !corrupt_r && cd.hit && (depth_r != '0);
  assign load         = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign walk_start   = (state_nxt == S_WALK) && (state_r != S_WALK);
  assign depth_prev   = depth_r - DW'(1);
  assign walk_prev    = walk_idx_r - DW'(1);

  // Saturate the open count at the field's range
  assign depth_w   = CW'(depth_r);
  assign depth_sat = (depth_w > CW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : depth_w[COUNT_W-1:0];

  // Stack RAM addressing
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = depth_r[AW-1:0];
    mem_raddr = walk_prev[AW-1:0];
    if (state_r == S_IDLE) begin
      mem_raddr = depth_prev[AW-1:0];
      mem_we    = in_fire && !corrupt_r && od.hit && (depth_r < DW'(STACK_DEPTH));
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (close_read) begin
            state_nxt = S_CMP;
          end else if (in_ch.line_end) begin
            state_nxt = corrupt_nxt ? S_FIN : S_WALK;
          end
        end
      end
      S_CMP: begin
        if (line_end_r) begin
          state_nxt = corrupt_nxt ? S_FIN : S_WALK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (!rd_pend_r && (walk_idx_r == '0)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Line state, walk and result datapath
  always_comb begin
    depth_nxt     = depth_r;
    corrupt_nxt   = corrupt_r;
    ovf_nxt       = ovf_r;
    kind_nxt      = kind_r;
    line_end_nxt  = line_end_r;
    walk_idx_nxt  = walk_idx_r;
    rd_pend_nxt   = rd_pend_r;
    score_nxt     = score_r;
    wrap_nxt      = wrap_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          line_end_nxt = in_ch.line_end;
          kind_nxt     = cd.kind;
          if (!corrupt_r) begin
            if (od.hit) begin
              if (depth_r < DW'(STACK_DEPTH)) begin
                depth_nxt = depth_r + DW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end else if (cd.hit && (depth_r == '0)) begin
              corrupt_nxt = 1'b1;
            end
          end
        end
      end
      S_CMP: begin
        // Compare the top of stack with the closing kind
        if (mem_rdata != kind_r) begin
          corrupt_nxt = 1'b1;
        end else begin
          depth_nxt = depth_prev;
        end
      end
      S_WALK: begin
        // Fold in the digit read last cycle, issue the next read
        if (rd_pend_r) begin
          score_nxt = mac_acc;
          wrap_nxt  = wrap_r | mac_carry;
        end
        if (walk_idx_r != '0) begin
          walk_idx_nxt = walk_prev;
          rd_pend_nxt  = 1'b1;
        end else begin
          rd_pend_nxt  = 1'b0;
        end
      end
      S_FIN: begin
        if (load) begin
          depth_nxt   = '0;
          corrupt_nxt = 1'b0;
          ovf_nxt     = 1'b0;
        end
      end
      default: ;
    endcase

    // Arm the walk from the depth left by this item
    if (walk_start) begin
      walk_idx_nxt = depth_nxt;
      rd_pend_nxt  = 1'b0;
      score_nxt    = '0;
      wrap_nxt     = 1'b0;
    end

    // Output register hand-off
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      corrupt_r   <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      walk_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      corrupt_r   <= corrupt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      walk_idx_r  <= walk_idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    line_end_r <= line_end_nxt;
    score_r    <= score_nxt;
    wrap_r     <= wrap_nxt;
    if (load) begin
      out_corrupt_r <= corrupt_r;
      out_score_r   <= corrupt_r ? '0 : score_r;
      out_count_r   <= depth_sat;
      out_ovf_r     <= ovf_r;
      out_wrap_r    <= corrupt_r ? 1'b0 : wrap_r;
    end
  end

  // Ports
  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.corrupt          = out_corrupt_r;
  assign out_ch.completion_score = out_score_r;
  assign out_ch.open_count       = out_count_r;
  assign out_ch.stack_overflow   = out_ovf_r;
  assign out_ch.score_wrapped    = out_wrap_r;

  // Checks
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_corrupt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.corrupt) |-> (out_ch.completion_score == '0) &&
      !out_ch.score_wrapped)
    else $error("corrupt line with non-zero score");

  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (depth_r == '0) && !corrupt_r && !ovf_r && out_ch.valid)
    else $error("line state not cleared after result load");

  a_walk_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) && rd_pend_r |-> !in_ch.ready && !corrupt_r)
    else $error("input taken or corrupt line during stack walk");

endmodule
